FILE: design/piecewise_legendre_eval_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise Legendre evaluation unit
// Immediate-consequence and next-cycle property forms used across the design.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LEGENDRE_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_LEGENDRE_EVAL_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PLE_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and constants of the piecewise Legendre evaluation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int MAX_ORDER_DEF    = 16;

	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	// Serial divider: dividend width, bits retired per cycle, steps per division.
	localparam int DIVD_W    = 40;
	localparam int DIV_DIGIT = 8;
	localparam int DIV_STEPS = DIVD_W / DIV_DIGIT;

	typedef enum logic [1:0] {
		OP_LOAD_KNOT = 2'd0,
		OP_LOAD_SEG  = 2'd1,
		OP_LOAD_COEF = 2'd2,
		OP_EVAL      = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEGMENTS = 1'b0,
		CFG_ORDER    = 1'b1
	} cfg_idx_t;

	// One queued request between the front and back parts.
	typedef struct packed {
		op_t                kind;
		logic [4:0]         slot;
		logic [3:0]         degree;
		logic signed [31:0] value;
		logic signed [31:0] scale;
		logic signed [31:0] norm;
	} item_t;

endpackage

`default_nettype wire

FILE: design/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/ple_div.sv
// ----------------------------------------------------------------------------
// ple_div
// Serial restoring divider by a narrow divisor, DIV_DIGIT quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_div #(
	parameter int DIV_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ple_pkg::DIVD_W-1:0]  dividend,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        busy,
	output logic [ple_pkg::DIVD_W-1:0]  quotient,
	output logic [DIV_W-1:0]            remainder
);

	import ple_pkg::*;

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic [DIVD_W-1:0]    work_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     d_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W-1:0]     rem_n;
	logic [DIV_DIGIT-1:0] qdig;

	// The dividend shifts out of the top of work_q while quotient bits enter at the bottom.
	always_comb begin
		rem_n = rem_q;
		trial = '0;
		qdig  = '0;
		for (int i = 0; i < DIV_DIGIT; i++) begin
			trial = {rem_n, work_q[DIVD_W-1-i]};
			if (trial >= {1'b0, d_q}) begin
				trial = trial - {1'b0, d_q};
				qdig[DIV_DIGIT-1-i] = 1'b1;
			end else begin
				qdig[DIV_DIGIT-1-i] = 1'b0;
			end
			rem_n = trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			d_q    <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			work_q <= {work_q[DIVD_W-DIV_DIGIT-1:0], qdig};
			rem_q  <= rem_n;
			cnt_q  <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

FILE: design/ple_front.sv
// ----------------------------------------------------------------------------
// ple_front
// Request intake: range check of load slots and a two-entry request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_front #(
	parameter int MAX_SEGMENTS = ple_pkg::MAX_SEGMENTS_DEF,
	parameter int MAX_ORDER    = ple_pkg::MAX_ORDER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [4:0]          slot,
	input  logic [3:0]          degree,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  scale,
	input  logic signed [31:0]  norm_factor,
	output logic                q_valid,
	output ple_pkg::item_t      q_item,
	input  logic                q_pop
);

	import ple_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       accept;
	logic       push;
	logic       seg_ok;
	item_t      item_in;

	// Loads aimed beyond the stores are taken and then dropped.
	always_comb begin
		seg_ok = {27'd0, slot} < 32'(MAX_SEGMENTS);
		unique case (op_t'(op))
			OP_LOAD_KNOT: keep = {27'd0, slot} < 32'(MAX_SEGMENTS + 1);
			OP_LOAD_SEG:  keep = seg_ok;
			OP_LOAD_COEF: keep = seg_ok && ({28'd0, degree} < 32'(MAX_ORDER));
			OP_EVAL:      keep = 1'b1;
			default:      keep = 1'b0;
		endcase
	end

	always_comb begin
		item_in.kind   = op_t'(op);
		item_in.slot   = slot;
		item_in.degree = degree;
		item_in.value  = value;
		item_in.scale  = scale;
		item_in.norm   = norm_factor;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign accept   = in_valid && in_ready;
	assign push     = accept && keep;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`include "piecewise_legendre_eval_unit_assert.svh"

	`PLE_ASSERT(a_pop_nonempty, q_pop, cnt_q != 2'd0, "pop from an empty request queue")
	`PLE_ASSERT(a_cnt_range, 1'b1, cnt_q <= 2'd2, "request queue count out of range")
	`PLE_ASSERT_NEXT(a_cnt_grow, push && !q_pop, cnt_q == $past(cnt_q) + 2'd1, "queue count lost a push")

endmodule

`default_nettype wire

FILE: design/ple_back.sv
// ----------------------------------------------------------------------------
// ple_back
// Execution part: store writes, knot scan, scaling and Clenshaw recurrence.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_back #(
	parameter int MAX_SEGMENTS = ple_pkg::MAX_SEGMENTS_DEF,
	parameter int MAX_ORDER    = ple_pkg::MAX_ORDER_DEF,
	localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1),
	localparam int OCNT_W = $clog2(MAX_ORDER + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SCNT_W-1:0]   nseg,
	input  logic [OCNT_W-1:0]   nord,
	input  logic                q_valid,
	input  ple_pkg::item_t      q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  result,
	output logic [3:0]          segment,
	output logic                out_of_domain
);

	import ple_pkg::*;

	localparam int KN_W   = $clog2(MAX_SEGMENTS + 2);
	localparam int KDEPTH = MAX_SEGMENTS + 1;
	localparam int KAW    = $clog2(KDEPTH);
	localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int ORD_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CDEPTH = MAX_ORDER * MAX_SEGMENTS;
	localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int DIV_W  = $clog2(MAX_ORDER + 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_PRD, ST_XMUL, ST_XRND, ST_CMUL, ST_CRND,
		ST_CDIV, ST_CCOMB, ST_NMUL, ST_NRND, ST_OUT
	} state_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = v;
		return v[31] ? (~u + 32'd1) : u;
	endfunction

	// Round a magnitude product by 2^16, ties away from zero, apply sign, saturate.
	function automatic logic signed [31:0] rnd16(input logic [64:0] p, input logic neg);
		logic [64:0] s;
		logic [48:0] r;
		s = p + 65'h8000;
		r = s[64:16];
		if (!neg) begin
			return (r > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
		end
		return (r > 49'h8000_0000) ? 32'sh8000_0000 : $signed(~r[31:0] + 32'd1);
	endfunction

	state_t                 state_q;
	logic signed [31:0]     x_q;
	logic [KN_W-1:0]        ridx_q;
	logic                   chk_v_s1;
	logic [KN_W-1:0]        chk_idx_s1;
	logic [SEG_W-1:0]       seg_q;
	logic                   ood_q;
	logic signed [31:0]     xt_q;
	logic signed [31:0]     norm_q;
	logic [64:0]            prod_q;
	logic                   neg_q;
	logic signed [31:0]     b1_q;
	logic signed [31:0]     b2_q;
	logic [ORD_W-1:0]       k_q;
	logic [32:0]            a_q;
	logic                   s1_q;
	logic signed [31:0]     coef_q;
	logic signed [31:0]     fin_res_q;
	logic                   fin_ood_q;
	logic                   out_valid_q;
	logic signed [31:0]     out_res_q;
	logic [3:0]             out_seg_q;
	logic                   out_ood_q;

	logic                   knot_we;
	logic [KAW-1:0]         knot_waddr;
	logic [KAW-1:0]         knot_raddr;
	logic [31:0]            knot_rdata;
	logic                   seg_we;
	logic [SEG_W-1:0]       seg_waddr;
	logic [95:0]            seg_wdata;
	logic [95:0]            seg_rdata;
	logic                   coef_we;
	logic [CAW-1:0]         coef_waddr;
	logic [CAW-1:0]         coef_raddr;
	logic [31:0]            coef_rdata;

	logic signed [31:0]     knot;
	logic                   scan_last;
	logic                   ood_n;
	logic signed [31:0]     mid;
	logic signed [31:0]     scl;
	logic [32:0]            diff;
	logic [32:0]            dmag;
	logic [64:0]            rsum30;
	logic [32:0]            a_n;
	logic                   div_start;
	logic [DIV_W-1:0]       d1;
	logic [DIV_W-1:0]       d2;
	logic                   div1_busy;
	logic                   div2_busy;
	logic [DIVD_W-1:0]      q1;
	logic [DIVD_W-1:0]      q2;
	logic [DIV_W-1:0]       r1;
	logic [DIV_W-1:0]       r2;
	logic                   f1;
	logic                   f2;
	logic [33:0]            t1m;
	logic [31:0]            t2m;
	logic signed [36:0]     t1s;
	logic signed [36:0]     t2s;
	logic signed [36:0]     bsum;
	logic signed [31:0]     b0;

	// Store writes happen in the cycle a load leaves the queue.
	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign knot_we    = q_pop && (q_item.kind == OP_LOAD_KNOT);
	assign seg_we     = q_pop && (q_item.kind == OP_LOAD_SEG);
	assign coef_we    = q_pop && (q_item.kind == OP_LOAD_COEF);
	assign knot_waddr = KAW'(q_item.slot);
	assign seg_waddr  = SEG_W'(q_item.slot);
	assign seg_wdata  = {q_item.value, q_item.scale, q_item.norm};
	assign coef_waddr = CAW'(int'(q_item.degree) * MAX_SEGMENTS + int'(q_item.slot));
	assign knot_raddr = ridx_q[KAW-1:0];
	assign coef_raddr = CAW'(int'(k_q) * MAX_SEGMENTS + int'(seg_q));

	ple_ram #(.WIDTH(32), .DEPTH(KDEPTH)) u_knot_ram (
		.clk(clk), .we(knot_we), .waddr(knot_waddr), .wdata(q_item.value),
		.raddr(knot_raddr), .rdata(knot_rdata)
	);

	ple_ram #(.WIDTH(96), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
		.clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
		.raddr(seg_q), .rdata(seg_rdata)
	);

	ple_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef_ram (
		.clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(q_item.value),
		.raddr(coef_raddr), .rdata(coef_rdata)
	);

	// Knot scan: the knot returned this cycle is for index chk_idx_s1.
	always_comb begin
		knot      = $signed(knot_rdata);
		scan_last = chk_v_s1 && (chk_idx_s1 == KN_W'(nseg));
		ood_n     = ood_q
			| (chk_v_s1 && (chk_idx_s1 == '0) && (x_q < knot))
			| (scan_last && (x_q > knot));
	end

	// Map x onto the segment: magnitude of (x - midpoint) for the scale multiply.
	always_comb begin
		mid  = $signed(seg_rdata[95:64]);
		scl  = $signed(seg_rdata[63:32]);
		diff = {x_q[31], x_q} - {mid[31], mid};
		dmag = diff[32] ? (~diff + 33'd1) : diff;
	end

	// Clenshaw step: x_tilde * b1 rounded by 2^30 feeds the first divider.
	always_comb begin
		rsum30    = prod_q + 65'h2000_0000;
		a_n       = rsum30[62:30];
		div_start = (state_q == ST_CRND);
		d1        = DIV_W'(k_q) + DIV_W'(1);
		d2        = DIV_W'(k_q) + DIV_W'(2);
	end

	ple_div #(.DIV_W(DIV_W)) u_div_t1 (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(DIVD_W'(a_n)),
		.divisor(d1), .busy(div1_busy), .quotient(q1), .remainder(r1)
	);

	ple_div #(.DIV_W(DIV_W)) u_div_t2 (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(DIVD_W'(mag32(b2_q))),
		.divisor(d2), .busy(div2_busy), .quotient(q2), .remainder(r2)
	);

	// a*(2k+1)/(k+1) = 2a - a/(k+1), and b*(k+1)/(k+2) = b - b/(k+2): rounding the
	// whole to nearest means taking the quotient up when the remainder exceeds half.
	always_comb begin
		f1   = {r1, 1'b0} > {1'b0, d1};
		f2   = {r2, 1'b0} > {1'b0, d2};
		t1m  = {a_q, 1'b0} - 34'(q1[32:0]) - 34'(f1);
		t2m  = mag32(b2_q) - q2[31:0] - 32'(f2);
		t1s  = s1_q ? -$signed({3'b000, t1m}) : $signed({3'b000, t1m});
		t2s  = b2_q[31] ? -$signed({5'b00000, t2m}) : $signed({5'b00000, t2m});
		bsum = 37'(coef_q) + t1s - t2s;
		if (bsum > 37'sh0_7FFF_FFFF) begin
			b0 = 32'sh7FFF_FFFF;
		end else if (bsum < -37'sh0_8000_0000) begin
			b0 = 32'sh8000_0000;
		end else begin
			b0 = bsum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chk_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In ST_OUT the output register is handled by the state itself.
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					chk_v_s1 <= 1'b0;
					if (q_valid && (q_item.kind == OP_EVAL)) begin
						x_q     <= q_item.value;
						ridx_q  <= '0;
						seg_q   <= '0;
						ood_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ridx_q <= KN_W'(nseg)) begin
						chk_v_s1   <= 1'b1;
						chk_idx_s1 <= ridx_q;
						ridx_q     <= ridx_q + KN_W'(1);
					end else begin
						chk_v_s1 <= 1'b0;
					end
					ood_q <= ood_n;
					if (chk_v_s1 && (chk_idx_s1 < KN_W'(nseg)) && (knot < x_q)) begin
						seg_q <= SEG_W'(chk_idx_s1);
					end
					if (scan_last) begin
						if (ood_n) begin
							fin_res_q <= '0;
							fin_ood_q <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_PRD;
						end
					end
				end
				ST_PRD: begin
					chk_v_s1 <= 1'b0;
					state_q  <= ST_XMUL;
				end
				ST_XMUL: begin
					prod_q  <= 65'(dmag) * 65'(mag32(scl));
					neg_q   <= diff[32] ^ scl[31];
					norm_q  <= $signed(seg_rdata[31:0]);
					state_q <= ST_XRND;
				end
				ST_XRND: begin
					xt_q    <= rnd16(prod_q, neg_q);
					b1_q    <= '0;
					b2_q    <= '0;
					k_q     <= ORD_W'(nord - OCNT_W'(1));
					state_q <= ST_CMUL;
				end
				ST_CMUL: begin
					prod_q  <= 65'(mag32(xt_q)) * 65'(mag32(b1_q));
					neg_q   <= xt_q[31] ^ b1_q[31];
					state_q <= ST_CRND;
				end
				ST_CRND: begin
					a_q     <= a_n;
					s1_q    <= neg_q;
					coef_q  <= $signed(coef_rdata);
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					if (!div1_busy && !div2_busy) begin
						state_q <= ST_CCOMB;
					end
				end
				ST_CCOMB: begin
					b2_q <= b1_q;
					b1_q <= b0;
					if (k_q == '0) begin
						state_q <= ST_NMUL;
					end else begin
						k_q     <= k_q - ORD_W'(1);
						state_q <= ST_CMUL;
					end
				end
				ST_NMUL: begin
					prod_q  <= 65'(mag32(b1_q)) * 65'(mag32(norm_q));
					neg_q   <= b1_q[31] ^ norm_q[31];
					state_q <= ST_NRND;
				end
				ST_NRND: begin
					fin_res_q <= rnd16(prod_q, neg_q);
					fin_ood_q <= 1'b0;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_res_q   <= fin_res_q;
						out_seg_q   <= fin_ood_q ? 4'd0 : 4'(seg_q);
						out_ood_q   <= fin_ood_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result        = out_res_q;
	assign segment       = out_seg_q;
	assign out_of_domain = out_ood_q;

	`include "piecewise_legendre_eval_unit_assert.svh"

	`PLE_ASSERT(a_div_lockstep, 1'b1, div1_busy == div2_busy, "dividers out of step")
	`PLE_ASSERT(a_ood_zero, out_valid_q && out_ood_q,
		(out_res_q == 32'sd0) && (out_seg_q == 4'd0), "out of domain result not zero")
	`PLE_ASSERT_NEXT(a_last_step, (state_q == ST_CCOMB) && (k_q == '0),
		state_q == ST_NMUL, "recurrence did not end at degree zero")
	`PLE_ASSERT(a_scan_bound, state_q == ST_SCAN,
		ridx_q <= (KN_W'(nseg) + KN_W'(1)), "knot scan ran past the last knot")

endmodule

`default_nettype wire

FILE: design/piecewise_legendre_eval_unit.sv
// ----------------------------------------------------------------------------
// piecewise_legendre_eval_unit
// Piecewise Legendre polynomial evaluation in fixed point, top level.
// ----------------------------------------------------------------------------
// Requests either load the knot, segment scaling and coefficient stores or
// evaluate at a point x (Q2.30). A front part takes requests, drops loads aimed
// beyond the stores and queues the rest two deep; the back part carries them
// out in order. A load is written into its store as it leaves the queue and
// returns nothing. An evaluation leaves the queue, scans the knots one a cycle,
// scales x into the segment, runs one Clenshaw step per coefficient (the
// product, its rounding, the two serial dividers that retire eight quotient
// bits a cycle, and the combine), then applies the norm and hands the result
// over, waiting while the receiver stalls. Results are Q16.16 and saturate; a
// point below the first knot or above the last knot in use returns zero with
// out_of_domain set. Stores are not cleared at reset, so every entry must be
// loaded before it is used.
// Configuration is to be written only while the block is idle, by the user;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_legendre_eval_unit #(
	parameter int MAX_SEGMENTS = ple_pkg::MAX_SEGMENTS_DEF,
	parameter int MAX_ORDER    = ple_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [4:0]                    slot,
	input  logic [3:0]                    degree,
	input  logic signed [31:0]            value,
	input  logic signed [31:0]            scale,
	input  logic signed [31:0]            norm_factor,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            result,
	output logic [3:0]                    segment,
	output logic                          out_of_domain,
	input  logic                          cfg_we,
	input  logic [ple_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ple_pkg::CFG_W-1:0]     cfg_wdata
);

	import ple_pkg::*;

	localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int OCNT_W = $clog2(MAX_ORDER + 1);

	logic [CFG_W-1:0]  seg_cfg_q;
	logic [CFG_W-1:0]  ord_cfg_q;
	logic [8:0]        seg_ext;
	logic [8:0]        ord_ext;
	logic [SCNT_W-1:0] nseg;
	logic [OCNT_W-1:0] nord;
	logic              q_valid;
	logic              q_pop;
	item_t             q_item;

	// Both registers reset to sixteen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= CFG_W'(16);
			ord_cfg_q <= CFG_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SEGMENTS: seg_cfg_q <= cfg_wdata;
				CFG_ORDER:    ord_cfg_q <= cfg_wdata;
				default:      seg_cfg_q <= seg_cfg_q;
			endcase
		end
	end

	// A zero count acts as one and a count above the store size as the store size.
	always_comb begin
		seg_ext = 9'(seg_cfg_q);
		ord_ext = 9'(ord_cfg_q);
		if (seg_ext == 9'd0) begin
			nseg = SCNT_W'(1);
		end else if (seg_ext > 9'(MAX_SEGMENTS)) begin
			nseg = SCNT_W'(MAX_SEGMENTS);
		end else begin
			nseg = SCNT_W'(seg_ext);
		end
		if (ord_ext == 9'd0) begin
			nord = OCNT_W'(1);
		end else if (ord_ext > 9'(MAX_ORDER)) begin
			nord = OCNT_W'(MAX_ORDER);
		end else begin
			nord = OCNT_W'(ord_ext);
		end
	end

	ple_front #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_ORDER(MAX_ORDER)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .slot(slot), .degree(degree), .value(value), .scale(scale),
		.norm_factor(norm_factor), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	ple_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_ORDER(MAX_ORDER)) u_back (
		.clk(clk), .arst_n(arst_n), .nseg(nseg), .nord(nord),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .result(result),
		.segment(segment), .out_of_domain(out_of_domain)
	);

endmodule

`default_nettype wire
